@@ hdl/gaussian_blur_3x3_rgb_top_macros.svh @@
// Assertion helpers for the blur top level.
`ifndef GAUSSIAN_BLUR_3X3_RGB_TOP_MACROS_SVH
`define GAUSSIAN_BLUR_3X3_RGB_TOP_MACROS_SVH

// same-cycle implication
`define GB3_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GB3_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/gb3_pkg.sv @@
package gb3_pkg;

   localparam int WEIGHT_BITS    = 16;
   localparam int K_BITS         = 2 * WEIGHT_BITS;
   localparam int PIX_BITS       = 8;
   localparam int CHANNELS       = 3;
   localparam int PIXEL_BITS     = CHANNELS * PIX_BITS;
   localparam int TAPS           = 9;
   localparam int PROD_BITS      = K_BITS + PIX_BITS;
   localparam int ROW_BITS       = PROD_BITS + 2;
   localparam int ACC_BITS       = PROD_BITS + 4;
   localparam int WSUM_BITS      = K_BITS + 4;
   localparam int DIV_STEPS      = 8;
   localparam int LANE_LAT       = 3 + DIV_STEPS;
   localparam int FIFO_DEPTH     = 32;
   localparam int FIFO_PTR_BITS  = 5;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int FW_BITS        = 11;
   localparam int FH_BITS        = 13;
   localparam int MODE_BITS      = 2;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [FW_BITS-1:0]     FW_RESET   = 11'd640;
   localparam logic [FH_BITS-1:0]     FH_RESET   = 13'd480;
   localparam logic [MODE_BITS-1:0]   MODE_RESET = 2'd2;
   localparam logic [WEIGHT_BITS-1:0] WC_RESET   = 16'd29067;
   localparam logic [WEIGHT_BITS-1:0] WS_RESET   = 16'd17630;

   localparam logic [MODE_BITS-1:0] MODE_ZERO   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_MIRROR = 2'd1;

   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_BORDER_MODE  = 3'd2,
      CSR_VERT_CENTER  = 3'd3,
      CSR_VERT_SIDE    = 3'd4,
      CSR_HORIZ_CENTER = 3'd5,
      CSR_HORIZ_SIDE   = 3'd6
   } csr_idx_type;

   typedef logic [PIX_BITS-1:0]   chan_type;
   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [K_BITS-1:0]     kw_type;

   // cc: vert center x horiz center, cs: vert center x horiz side, etc.
   typedef struct packed {
      kw_type cc;
      kw_type cs;
      kw_type sc;
      kw_type ss;
   } weights_type;

   typedef struct packed {
      kw_type    [TAPS-1:0] k;
      pixel_type [TAPS-1:0] pix;
      logic [WSUM_BITS-1:0] wsum;
      logic                 renorm;
      logic                 row_end;
      logic                 frame_end;
   } job_type;

   typedef struct packed {
      logic row_end;
      logic frame_end;
   } side_type;

   typedef struct packed {
      logic busy;
      logic pair;
   } front_stat_type;

endpackage

@@ hdl/gaussian_blur_3x3_rgb_top.sv @@
// 3x3 Gaussian blur on a raster RGB stream, one pixel per beat.
// req channel: tdata carries the three 8-bit channels, tuser says pixel (0)
//   or drain tick (1). Drain ticks after the last pixel of a frame push out
//   the final row, one tick per column; ticks mid-frame and pixels between
//   frame end and the end of the drain are dropped without a result.
// rsp channel: tdata carries the filtered channels, tlast marks the last
//   pixel of a row, tuser the last pixel of the frame.
// csr port: csr_we/csr_idx/csr_wdata write size, border mode and the four
//   Q0.16 tap weights; write only while the stream is idle.
// Throughput: one beat per clock unless held off. A row-end beat past the first
//   row (and the last drain tick) yields two results and blocks the input in
//   the next cycle; queued results drain one per clock while rsp_tready is high.
// Pipeline: the line-store read, tap multiply, two add stages and the 8-step
//   divider lie between an input beat and its first result on rsp.
// Reset: counters, window and queue cleared, registers back to 640x480,
//   renormalize mode, default weights. Line store is not cleared.
// Back pressure: results collect in a 32-entry queue; the input is held off
//   once queue plus in-flight results near its depth.
`include "gaussian_blur_3x3_rgb_top_macros.svh"

module gaussian_blur_3x3_rgb_top #(
   parameter int MAX_WIDTH  = gb3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gb3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [23:0]                           req_tdata,  // in_chan0, in_chan1, in_chan2
   input  logic                                  req_tuser,  // func
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [23:0]                           rsp_tdata,  // out_chan0, out_chan1, out_chan2
   output logic                                  rsp_tlast,  // row_end
   output logic                                  rsp_tuser,  // frame_end
   input  logic                                  csr_we,
   input  logic [gb3_pkg::CSR_IDX_BITS-1:0]      csr_idx,
   input  logic [gb3_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int CNT_BITS = gb3_pkg::FIFO_PTR_BITS + 1;
   localparam int WB       = gb3_pkg::WEIGHT_BITS;
   localparam int KB       = gb3_pkg::K_BITS;

   // configuration registers
   logic [gb3_pkg::FW_BITS-1:0]   fw_ff;
   logic [gb3_pkg::FH_BITS-1:0]   fh_ff;
   logic [gb3_pkg::MODE_BITS-1:0] mode_ff;
   logic [WB-1:0]                 vc_ff, vs_ff, hc_ff, hs_ff;
   gb3_pkg::weights_type          wts_ff;

   logic [CNT_BITS-1:0] out_cnt_ff;
   logic                req_fire, rsp_fire;

   gb3_pkg::front_stat_type front_stat;
   logic                    job_valid;
   gb3_pkg::job_type        job;
   gb3_pkg::side_type       job_side;

   gb3_pkg::chan_type [gb3_pkg::TAPS-1:0]     lane_pix [gb3_pkg::CHANNELS];
   gb3_pkg::chan_type [gb3_pkg::CHANNELS-1:0] lane_out;
   gb3_pkg::chan_type [gb3_pkg::CHANNELS-1:0] out_chans;
   gb3_pkg::side_type                         out_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff   <= gb3_pkg::FW_RESET;
         fh_ff   <= gb3_pkg::FH_RESET;
         mode_ff <= gb3_pkg::MODE_RESET;
         vc_ff   <= gb3_pkg::WC_RESET;
         vs_ff   <= gb3_pkg::WS_RESET;
         hc_ff   <= gb3_pkg::WC_RESET;
         hs_ff   <= gb3_pkg::WS_RESET;
      end else if (csr_we) begin
         case (gb3_pkg::csr_idx_type'(csr_idx))
            gb3_pkg::CSR_FRAME_WIDTH:  fw_ff   <= csr_wdata[gb3_pkg::FW_BITS-1:0];
            gb3_pkg::CSR_FRAME_HEIGHT: fh_ff   <= csr_wdata[gb3_pkg::FH_BITS-1:0];
            gb3_pkg::CSR_BORDER_MODE:  mode_ff <= csr_wdata[gb3_pkg::MODE_BITS-1:0];
            gb3_pkg::CSR_VERT_CENTER:  vc_ff   <= csr_wdata[WB-1:0];
            gb3_pkg::CSR_VERT_SIDE:    vs_ff   <= csr_wdata[WB-1:0];
            gb3_pkg::CSR_HORIZ_CENTER: hc_ff   <= csr_wdata[WB-1:0];
            gb3_pkg::CSR_HORIZ_SIDE:   hs_ff   <= csr_wdata[WB-1:0];
            default: ;
         endcase
      end
   end

   // 2-D tap weights as products of the 1-D vectors, refreshed every cycle
   always_ff @(posedge clock) begin
      wts_ff.cc <= KB'(vc_ff) * KB'(hc_ff);
      wts_ff.cs <= KB'(vc_ff) * KB'(hs_ff);
      wts_ff.sc <= KB'(vs_ff) * KB'(hc_ff);
      wts_ff.ss <= KB'(vs_ff) * KB'(hs_ff);
   end

   // credit: results in flight past the job register plus queued results
   assign req_tready = !front_stat.busy &&
                       (out_cnt_ff <= CNT_BITS'(gb3_pkg::FIFO_DEPTH - 4));
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) out_cnt_ff <= '0;
      else out_cnt_ff <= out_cnt_ff + CNT_BITS'(job_valid) - CNT_BITS'(rsp_fire);
   end

   gb3_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_fire      (req_fire),
      .in_func      (req_tuser),
      .in_pixel     (req_tdata),
      .frame_width  (fw_ff),
      .frame_height (fh_ff),
      .border_mode  (mode_ff),
      .weights      (wts_ff),
      .stat         (front_stat),
      .job_valid    (job_valid),
      .job          (job)
   );

   // one lane per color channel
   always_comb begin
      for (int ch = 0; ch < gb3_pkg::CHANNELS; ch++) begin
         for (int t = 0; t < gb3_pkg::TAPS; t++) begin
            lane_pix[ch][t] = job.pix[t][ch*gb3_pkg::PIX_BITS +: gb3_pkg::PIX_BITS];
         end
      end
   end

   for (genvar ch = 0; ch < gb3_pkg::CHANNELS; ch++) begin : g_lane
      gb3_lane u_lane (
         .clock  (clock),
         .k      (job.k),
         .pix    (lane_pix[ch]),
         .wsum   (job.wsum),
         .renorm (job.renorm),
         .result (lane_out[ch])
      );
   end

   assign job_side.row_end   = job.row_end;
   assign job_side.frame_end = job.frame_end;

   gb3_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (job_valid),
      .in_side     (job_side),
      .lane_result (lane_out),
      .out_ready   (rsp_tready),
      .out_valid   (rsp_tvalid),
      .out_chans   (out_chans),
      .out_side    (out_side)
   );

   assign rsp_tdata = {out_chans[2], out_chans[1], out_chans[0]};
   assign rsp_tlast = out_side.row_end;
   assign rsp_tuser = out_side.frame_end;

   `GB3_ASSERT_IMP(a_credit_bound, 1'b1, out_cnt_ff <= CNT_BITS'(gb3_pkg::FIFO_DEPTH), "result credit overrun")
   `GB3_ASSERT_NXT(a_pair_blocks_input, front_stat.pair, !req_tready, "input taken during row-end pair")
   `GB3_ASSERT_IMP(a_rsp_has_credit, rsp_tvalid, out_cnt_ff != '0, "result shown without credit")

endmodule

@@ hdl/gb3_front.sv @@
module gb3_front #(
   parameter int MAX_WIDTH  = gb3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gb3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_fire,
   input  logic                                in_func,
   input  gb3_pkg::pixel_type                  in_pixel,
   input  logic [gb3_pkg::FW_BITS-1:0]         frame_width,
   input  logic [gb3_pkg::FH_BITS-1:0]         frame_height,
   input  logic [gb3_pkg::MODE_BITS-1:0]       border_mode,
   input  gb3_pkg::weights_type                weights,
   output gb3_pkg::front_stat_type             stat,
   output logic                                job_valid,
   output gb3_pkg::job_type                    job
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WDW = (gb3_pkg::FW_BITS > CW + 1) ? gb3_pkg::FW_BITS : CW + 1;
   localparam int HDW = (gb3_pkg::FH_BITS > RW + 1) ? gb3_pkg::FH_BITS : RW + 1;
   localparam int PB  = gb3_pkg::PIXEL_BITS;

   logic [CW-1:0] col_ff, col_in, drain_ff, drain_in, cur;
   logic [RW-1:0] row_ff, row_in;
   logic          done_ff, done_in;
   logic [WDW-1:0] fw_ext, w_use, cur_plus;
   logic [HDW-1:0] fh_ext, h_use, row_plus;
   logic is_drain, pix_go, drn_go, go, row_ends, row_last, first, pair;

   // stage B
   logic               b_valid_ff, hold_ff, j2_ff;
   logic               b_drain_ff, b_first_ff, b_pair_ff, b_top_ff, b_bot_ff, b_left_ff;
   gb3_pkg::pixel_type b_px_ff;
   logic [CW-1:0]      b_addr_ff;

   // two rows per word: {older row, newer row}
   logic [2*PB-1:0] line_mem [MAX_WIDTH];
   logic [2*PB-1:0] rd_ff;

   gb3_pkg::pixel_type win_ff   [3][3];
   gb3_pkg::pixel_type win_next [3][3];
   gb3_pkg::pixel_type src      [3][3];
   logic top_ok, bot_ok, left_ok, right_ok, j_rend, j_fend, job_v;

   gb3_pkg::job_type job_in, job_ff;
   logic             job_valid_ff;

   always_comb begin
      fw_ext = WDW'(frame_width);
      if (fw_ext < WDW'(2)) w_use = WDW'(2);
      else if (fw_ext > WDW'(MAX_WIDTH)) w_use = WDW'(MAX_WIDTH);
      else w_use = fw_ext;
      fh_ext = HDW'(frame_height);
      if (fh_ext < HDW'(2)) h_use = HDW'(2);
      else if (fh_ext > HDW'(MAX_HEIGHT)) h_use = HDW'(MAX_HEIGHT);
      else h_use = fh_ext;

      is_drain = (in_func == gb3_pkg::FUNC_DRAIN);
      cur      = is_drain ? drain_ff : col_ff;
      cur_plus = WDW'(cur) + WDW'(1);
      row_ends = (cur_plus >= w_use);
      row_plus = HDW'(row_ff) + HDW'(1);
      row_last = (row_plus >= h_use);
      pix_go   = in_fire && !is_drain && !done_ff;
      drn_go   = in_fire && is_drain && done_ff;
      go       = pix_go || drn_go;
      first    = is_drain ? (drain_ff != '0) : ((row_ff != '0) && (col_ff != '0));
      pair     = first && row_ends;
   end

   assign stat.busy = hold_ff;
   assign stat.pair = go && pair;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      done_in  = done_ff;
      if (pix_go) begin
         if (row_ends) begin
            col_in = '0;
            if (row_last) done_in = 1'b1;
            else row_in = RW'(row_plus);
         end else begin
            col_in = CW'(cur_plus);
         end
      end else if (drn_go) begin
         if (row_ends) begin
            drain_in = '0;
            col_in   = '0;
            row_in   = '0;
            done_in  = 1'b0;
         end else begin
            drain_in = CW'(cur_plus);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) rd_ff <= line_mem[cur];
      if (b_valid_ff && !b_drain_ff) line_mem[b_addr_ff] <= {rd_ff[PB-1:0], b_px_ff};
   end

   always_ff @(posedge clock) begin
      if (go) begin
         b_drain_ff <= is_drain;
         b_px_ff    <= in_pixel;
         b_addr_ff  <= cur;
         b_first_ff <= first;
         b_pair_ff  <= pair;
         b_top_ff   <= is_drain ? (row_ff != '0) : (row_ff >= RW'(2));
         b_bot_ff   <= !is_drain;
         b_left_ff  <= (cur >= CW'(2));
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_next[r][0] = win_ff[r][1];
         win_next[r][1] = win_ff[r][2];
      end
      win_next[0][2] = rd_ff[2*PB-1:PB];
      win_next[1][2] = rd_ff[PB-1:0];
      win_next[2][2] = b_drain_ff ? '0 : b_px_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         drain_ff     <= '0;
         done_ff      <= 1'b0;
         b_valid_ff   <= 1'b0;
         hold_ff      <= 1'b0;
         j2_ff        <= 1'b0;
         job_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) win_ff[r][c] <= '0;
         end
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         drain_ff     <= drain_in;
         done_ff      <= done_in;
         b_valid_ff   <= go;
         hold_ff      <= go && pair;
         j2_ff        <= b_valid_ff && b_pair_ff;
         job_valid_ff <= job_v;
         if (b_valid_ff) win_ff <= win_next;
      end
   end

   // second beat of a row end: window moved one column, right column outside
   always_comb begin
      top_ok = b_top_ff;
      bot_ok = b_bot_ff;
      if (j2_ff) begin
         for (int r = 0; r < 3; r++) begin
            src[r][0] = win_ff[r][1];
            src[r][1] = win_ff[r][2];
            src[r][2] = '0;
         end
         left_ok  = 1'b1;
         right_ok = 1'b0;
         j_rend   = 1'b1;
         j_fend   = b_drain_ff;
      end else begin
         src      = win_next;
         left_ok  = b_left_ff;
         right_ok = 1'b1;
         j_rend   = 1'b0;
         j_fend   = 1'b0;
      end
      job_v = j2_ff || (b_valid_ff && b_first_ff);
   end

   always_comb begin
      int ra;
      int cb;
      logic rv;
      logic cv;
      logic mirror;
      gb3_pkg::kw_type kk;
      mirror        = (border_mode == gb3_pkg::MODE_MIRROR);
      job_in.renorm = !(mirror || (border_mode == gb3_pkg::MODE_ZERO));
      job_in.row_end   = j_rend;
      job_in.frame_end = j_fend;
      job_in.wsum      = '0;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            rv = (a == 0) ? top_ok : ((a == 2) ? bot_ok : 1'b1);
            cv = (b == 0) ? left_ok : ((b == 2) ? right_ok : 1'b1);
            if (a == 1) kk = (b == 1) ? weights.cc : weights.cs;
            else kk = (b == 1) ? weights.sc : weights.ss;
            ra = rv ? a : 2 - a;
            cb = cv ? b : 2 - b;
            if (mirror) begin
               job_in.k[a*3+b]   = kk;
               job_in.pix[a*3+b] = src[ra][cb];
            end else if (rv && cv) begin
               job_in.k[a*3+b]   = kk;
               job_in.pix[a*3+b] = src[a][b];
            end else begin
               job_in.k[a*3+b]   = '0;
               job_in.pix[a*3+b] = '0;
            end
            job_in.wsum = job_in.wsum + gb3_pkg::WSUM_BITS'(job_in.k[a*3+b]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_v) job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

@@ hdl/gb3_lane.sv @@
module gb3_lane (
   input  logic                                       clock,
   input  gb3_pkg::kw_type   [gb3_pkg::TAPS-1:0]      k,
   input  gb3_pkg::chan_type [gb3_pkg::TAPS-1:0]      pix,
   input  logic [gb3_pkg::WSUM_BITS-1:0]              wsum,
   input  logic                                       renorm,
   output gb3_pkg::chan_type                          result
);

   localparam int PRB = gb3_pkg::PROD_BITS;
   localparam int RWB = gb3_pkg::ROW_BITS;
   localparam int AB  = gb3_pkg::ACC_BITS;
   localparam int WSB = gb3_pkg::WSUM_BITS;
   localparam int KB  = gb3_pkg::K_BITS;
   localparam int NS  = gb3_pkg::DIV_STEPS;

   logic [PRB-1:0] prod_ff [gb3_pkg::TAPS];
   logic [WSB-1:0] wsum_p_ff, wsum_r_ff;
   logic           renorm_p_ff, renorm_r_ff;
   logic [RWB-1:0] row_ff [3];

   logic [AB-1:0]    acc;
   logic [AB-KB-1:0] high;
   gb3_pkg::chan_type direct;

   logic [AB-1:0]     rem_ff  [NS];
   logic [WSB-1:0]    dvs_ff  [NS];
   logic [AB-1:0]     trial   [NS];
   gb3_pkg::chan_type q_ff    [NS+1];
   gb3_pkg::chan_type alt_ff  [NS+1];
   logic              useq_ff [NS+1];

   always_ff @(posedge clock) begin
      for (int t = 0; t < gb3_pkg::TAPS; t++) prod_ff[t] <= PRB'(k[t]) * PRB'(pix[t]);
      wsum_p_ff   <= wsum;
      renorm_p_ff <= renorm;
      for (int r = 0; r < 3; r++) begin
         row_ff[r] <= RWB'(prod_ff[3*r]) + RWB'(prod_ff[3*r+1]) + RWB'(prod_ff[3*r+2]);
      end
      wsum_r_ff   <= wsum_p_ff;
      renorm_r_ff <= renorm_p_ff;
   end

   always_comb begin
      acc    = AB'(row_ff[0]) + AB'(row_ff[1]) + AB'(row_ff[2]);
      high   = acc[AB-1:KB];
      direct = (high > (AB-KB)'(255)) ? 8'd255 : high[7:0];
      for (int s = 0; s < NS; s++) trial[s] = AB'(dvs_ff[s]) << (NS - 1 - s);
   end

   // restoring divide, one quotient bit per stage; quotient never exceeds 255
   always_ff @(posedge clock) begin
      rem_ff[0]  <= acc;
      dvs_ff[0]  <= wsum_r_ff;
      q_ff[0]    <= '0;
      useq_ff[0] <= renorm_r_ff && (wsum_r_ff != '0);
      alt_ff[0]  <= renorm_r_ff ? '0 : direct;
      for (int s = 0; s < NS; s++) begin
         q_ff[s+1]    <= q_ff[s] |
                         (gb3_pkg::chan_type'(rem_ff[s] >= trial[s]) << (NS - 1 - s));
         useq_ff[s+1] <= useq_ff[s];
         alt_ff[s+1]  <= alt_ff[s];
      end
      for (int s = 0; s < NS - 1; s++) begin
         rem_ff[s+1] <= (rem_ff[s] >= trial[s]) ? rem_ff[s] - trial[s] : rem_ff[s];
         dvs_ff[s+1] <= dvs_ff[s];
      end
   end

   assign result = useq_ff[NS] ? q_ff[NS] : alt_ff[NS];

endmodule

@@ hdl/gb3_merge.sv @@
module gb3_merge (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  gb3_pkg::side_type                             in_side,
   input  gb3_pkg::chan_type [gb3_pkg::CHANNELS-1:0]     lane_result,
   input  logic                                          out_ready,
   output logic                                          out_valid,
   output gb3_pkg::chan_type [gb3_pkg::CHANNELS-1:0]     out_chans,
   output gb3_pkg::side_type                             out_side
);

   localparam int LL = gb3_pkg::LANE_LAT;
   localparam int PW = gb3_pkg::FIFO_PTR_BITS;

   typedef struct packed {
      gb3_pkg::chan_type [gb3_pkg::CHANNELS-1:0] chans;
      gb3_pkg::side_type                         side;
   } entry_type;

   logic              valid_ff [LL];
   gb3_pkg::side_type side_ff  [LL];

   entry_type      fifo_mem [gb3_pkg::FIFO_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]    cnt_ff;
   logic           push, pop;

   assign push      = valid_ff[LL-1];
   assign out_valid = (cnt_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_chans = fifo_mem[rd_ptr_ff].chans;
   assign out_side  = fifo_mem[rd_ptr_ff].side;

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      for (int i = 1; i < LL; i++) side_ff[i] <= side_ff[i-1];
      if (push) fifo_mem[wr_ptr_ff] <= '{chans: lane_result, side: side_ff[LL-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LL; i++) valid_ff[i] <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < LL; i++) valid_ff[i] <= valid_ff[i-1];
         if (push) wr_ptr_ff <= wr_ptr_ff + PW'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + PW'(1);
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

endmodule
